FILE: hw/rtl/sle_pkg.sv
`default_nettype none

package sle_pkg;

   // Width of the key and payload words.
   localparam int unsigned WordW = 32;
   // Width of the request position field.
   localparam int unsigned PosW = 4;
   // Width of the reported entry count.
   localparam int unsigned CountOutW = 5;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_DELETE = 2'd1,
      OP_READ   = 2'd2,
      OP_COUNT  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_FULL   = 2'd1,
      ST_BADPOS = 2'd2
   } status_type;

   // Command broadcast to every cell of the row in the cycle a word is accepted.
   typedef struct packed {
      logic             do_insert;
      logic             do_delete;
      logic [WordW-1:0] new_key;
      logic [WordW-1:0] new_value;
   } ctrl_type;

endpackage

`default_nettype wire

FILE: hw/rtl/sorted_list_engine.sv
`default_nettype none

// Sorted list engine: holds up to LIST_DEPTH (key, value) entries in
// ascending key order in a row of cells, one entry per cell.
// A request word is taken at a rising edge where start is high and busy is
// low. busy never rises: every request finishes in the cycle it is taken,
// so one word per clock is accepted. The request selects insert, delete at
// a position, read at a position, or a count query.
// Exactly one result word follows each request, in the cycle right after
// acceptance, marked by rsp_valid for one cycle; the sustained rate is
// one request per cycle. Insert and delete shift the whole row in the
// cycle the word is taken, each cell comparing its key with the new key
// and loading from its own neighbor; a read goes through one position mux.
// The receiver cannot stall; a result must be taken when rsp_valid is high.
// Each result carries the count held after the request and a status:
// ok, list full on insert, or position not held on delete and read.
// Reset empties the list by clearing the count; the stored words are left
// as they are, since no entry at or past the count is ever read.

module sorted_list_engine
   import sle_pkg::*;
#(
   parameter int LIST_DEPTH = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire logic [1:0]           req_op,
   input  wire logic [WordW-1:0]     req_item_key,
   input  wire logic [WordW-1:0]     req_item_value,
   input  wire logic [PosW-1:0]      req_position,
   output logic                      rsp_valid,
   output logic [WordW-1:0]          rsp_found_key,
   output logic [WordW-1:0]          rsp_found_value,
   output logic [CountOutW-1:0]      rsp_entry_count,
   output logic [1:0]                rsp_status
);

   localparam int CountW = $clog2(LIST_DEPTH + 1);
   localparam int ExtW   = (CountW > CountOutW) ? CountW : CountOutW;
   // Only the first positions that the request field can name are readable.
   localparam int ReadN  = (LIST_DEPTH < (1 << PosW)) ? LIST_DEPTH : (1 << PosW);

   logic [CountW-1:0]    count_ff, count_in;
   logic                 rsp_valid_ff;
   logic [WordW-1:0]     rsp_found_key_ff, rsp_found_key_in;
   logic [WordW-1:0]     rsp_found_value_ff, rsp_found_value_in;
   logic [CountOutW-1:0] rsp_entry_count_ff;
   logic [1:0]           rsp_status_ff;
   status_type           status_in;
   ctrl_type             ctrl;
   logic                 accept;
   logic                 full;
   logic                 pos_held;
   logic [ExtW-1:0]      count_ext;
   op_type               op;

   logic                 cell_pass  [LIST_DEPTH];
   logic [WordW-1:0]     cell_key   [LIST_DEPTH];
   logic [WordW-1:0]     cell_value [LIST_DEPTH];

   assign busy     = 1'b0;
   assign accept   = start && !busy;
   assign op       = op_type'(req_op);
   assign full     = count_ff == CountW'(LIST_DEPTH);
   assign pos_held = 32'(req_position) < 32'(count_ff);

   // Decode the request and work out the result word.
   always_comb begin
      ctrl.do_insert     = 1'b0;
      ctrl.do_delete     = 1'b0;
      ctrl.new_key       = req_item_key;
      ctrl.new_value     = req_item_value;
      count_in           = count_ff;
      status_in          = ST_OK;
      rsp_found_key_in   = '0;
      rsp_found_value_in = '0;
      if (accept) begin
         case (op)
            OP_INSERT: begin
               if (full) begin
                  status_in = ST_FULL;
               end else begin
                  ctrl.do_insert = 1'b1;
                  count_in       = count_ff + CountW'(1);
               end
            end
            OP_DELETE: begin
               if (!pos_held) begin
                  status_in = ST_BADPOS;
               end else begin
                  ctrl.do_delete = 1'b1;
                  count_in       = count_ff - CountW'(1);
               end
            end
            OP_READ: begin
               if (!pos_held) begin
                  status_in = ST_BADPOS;
               end else begin
                  for (int i = 0; i < ReadN; i++) begin
                     if (PosW'(i) == req_position) begin
                        rsp_found_key_in   = cell_key[i];
                        rsp_found_value_in = cell_value[i];
                     end
                  end
               end
            end
            default: begin
               // A count query leaves the list alone.
            end
         endcase
      end
   end

   // The count field is the low bits of the held count.
   assign count_ext = ExtW'(count_in);

   // The row of cells; each one looks at its left neighbor on insert and
   // at its right neighbor on delete.
   for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_cell
      logic             left_pass;
      logic [WordW-1:0] left_key, left_value, right_key, right_value;

      if (g == 0) begin : g_first
         assign left_pass  = 1'b0;
         assign left_key   = req_item_key;
         assign left_value = req_item_value;
      end else begin : g_inner
         assign left_pass  = cell_pass[g-1];
         assign left_key   = cell_key[g-1];
         assign left_value = cell_value[g-1];
      end

      if (g == LIST_DEPTH - 1) begin : g_last
         // The last cell falls outside the list on delete, so it may keep
         // its own entry.
         assign right_key   = cell_key[g];
         assign right_value = cell_value[g];
      end else begin : g_body
         assign right_key   = cell_key[g+1];
         assign right_value = cell_value[g+1];
      end

      sle_cell #(
         .INDEX  (g),
         .CountW (CountW)
      ) u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .count       (count_ff),
         .position    (req_position),
         .left_pass   (left_pass),
         .left_key    (left_key),
         .left_value  (left_value),
         .right_key   (right_key),
         .right_value (right_value),
         .pass        (cell_pass[g]),
         .key         (cell_key[g]),
         .value       (cell_value[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= accept;
      end
      rsp_found_key_ff   <= rsp_found_key_in;
      rsp_found_value_ff <= rsp_found_value_in;
      rsp_entry_count_ff <= count_ext[CountOutW-1:0];
      rsp_status_ff      <= status_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_found_key   = rsp_found_key_ff;
   assign rsp_found_value = rsp_found_value_ff;
   assign rsp_entry_count = rsp_entry_count_ff;
   assign rsp_status      = rsp_status_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/sle_cell.sv
`default_nettype none

module sle_cell
   import sle_pkg::*;
#(
   parameter int INDEX = 0,
   parameter int CountW = 5
) (
   input  wire logic              clock,
   input  wire ctrl_type          ctrl,
   input  wire logic [CountW-1:0] count,
   input  wire logic [PosW-1:0]   position,
   input  wire logic              left_pass,
   input  wire logic [WordW-1:0]  left_key,
   input  wire logic [WordW-1:0]  left_value,
   input  wire logic [WordW-1:0]  right_key,
   input  wire logic [WordW-1:0]  right_value,
   output logic                   pass,
   output logic [WordW-1:0]       key,
   output logic [WordW-1:0]       value
);

   logic [WordW-1:0] key_ff, key_in;
   logic [WordW-1:0] value_ff, value_in;
   logic             held;
   logic             at_or_after_pos;

   // An empty cell acts as if it held an infinitely large key, so the
   // pass flags along the row form one step from low to high.
   assign held            = 32'(INDEX) < 32'(count);
   assign at_or_after_pos = 32'(position) <= 32'(INDEX);
   assign pass            = !held || (key_ff >= ctrl.new_key);

   always_comb begin
      key_in   = key_ff;
      value_in = value_ff;
      if (ctrl.do_insert && pass) begin
         // The first cell whose flag is set takes the new entry, the ones
         // after it take their left neighbor's entry.
         if (left_pass) begin
            key_in   = left_key;
            value_in = left_value;
         end else begin
            key_in   = ctrl.new_key;
            value_in = ctrl.new_value;
         end
      end else if (ctrl.do_delete && at_or_after_pos) begin
         key_in   = right_key;
         value_in = right_value;
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      value_ff <= value_in;
   end

   assign key   = key_ff;
   assign value = value_ff;

endmodule

`default_nettype wire

FILE: sim/sorted_list_checker.sv
`default_nettype none

// Watches both channels of the sorted list engine, keeps its own copy of
// the list, and compares every result word with the oldest prediction.
module sorted_list_checker
   import sle_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic                 busy,
   input  wire logic [1:0]           req_op,
   input  wire logic [WordW-1:0]     req_item_key,
   input  wire logic [WordW-1:0]     req_item_value,
   input  wire logic [PosW-1:0]      req_position,
   input  wire logic                 rsp_valid,
   input  wire logic [WordW-1:0]     rsp_found_key,
   input  wire logic [WordW-1:0]     rsp_found_value,
   input  wire logic [CountOutW-1:0] rsp_entry_count,
   input  wire logic [1:0]           rsp_status,
   output int                        mismatches,
   output int                        outstanding,
   output int                        fill_level,
   output int                        full_replies,
   output int                        badpos_replies
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [WordW-1:0]     key;
      logic [WordW-1:0]     value;
      logic [CountOutW-1:0] count;
      status_type           status;
   } list_reply_type;

   logic [WordW-1:0] shadow_keys [DEPTH];
   logic [WordW-1:0] shadow_values [DEPTH];
   int held;
   list_reply_type awaited_replies[$];

   initial begin
      held = 0;
      mismatches = 0;
      outstanding = 0;
      fill_level = 0;
      full_replies = 0;
      badpos_replies = 0;
   end

   // Applies one request to the shadow list and returns the reply it earns.
   function automatic list_reply_type apply_request(op_type op, logic [WordW-1:0] key,
                                                    logic [WordW-1:0] value,
                                                    logic [PosW-1:0] pos);
      list_reply_type r;
      int slot;
      r.key = '0;
      r.value = '0;
      r.status = ST_OK;
      case (op)
         OP_INSERT: begin
            if (held >= DEPTH) begin
               r.status = ST_FULL;
            end else begin
               slot = 0;
               while (slot < held && shadow_keys[slot] < key) slot++;
               for (int i = held; i > slot; i--) begin
                  shadow_keys[i] = shadow_keys[i-1];
                  shadow_values[i] = shadow_values[i-1];
               end
               shadow_keys[slot] = key;
               shadow_values[slot] = value;
               held++;
            end
         end
         OP_DELETE: begin
            if (int'(pos) >= held) begin
               r.status = ST_BADPOS;
            end else begin
               for (int i = int'(pos); i + 1 < held; i++) begin
                  shadow_keys[i] = shadow_keys[i+1];
                  shadow_values[i] = shadow_values[i+1];
               end
               held--;
            end
         end
         OP_READ: begin
            if (int'(pos) < held) begin
               r.key = shadow_keys[pos];
               r.value = shadow_values[pos];
            end else begin
               r.status = ST_BADPOS;
            end
         end
         default: ;
      endcase
      r.count = CountOutW'(held);
      return r;
   endfunction

   task automatic note_mismatch(string what);
      mismatches++;
      if (mismatches <= 10) $display("[%0t] MISMATCH %s", $realtime, what);
   endtask

   always @(posedge clock) begin
      list_reply_type want;
      list_reply_type got;
      if (reset) begin
         held = 0;
         awaited_replies.delete();
      end else begin
         // The result on the ports belongs to a word taken at an earlier edge,
         // so it is checked before this edge's word is predicted.
         if (rsp_valid) begin
            if (awaited_replies.size() == 0) begin
               note_mismatch($sformatf("unexpected result key=%h value=%h count=%0d status=%0d",
                                       rsp_found_key, rsp_found_value, rsp_entry_count,
                                       rsp_status));
            end else begin
               want = awaited_replies.pop_front();
               if (rsp_found_key !== want.key || rsp_found_value !== want.value ||
                   rsp_entry_count !== want.count || rsp_status !== want.status) begin
                  note_mismatch($sformatf({"expected key=%h value=%h count=%0d status=%0d,",
                                           " got key=%h value=%h count=%0d status=%0d"},
                                          want.key, want.value, want.count, want.status,
                                          rsp_found_key, rsp_found_value, rsp_entry_count,
                                          rsp_status));
               end
            end
         end
         if (start && !busy) begin
            got = apply_request(op_type'(req_op), req_item_key, req_item_value, req_position);
            if (got.status == ST_FULL) full_replies++;
            if (got.status == ST_BADPOS) badpos_replies++;
            awaited_replies.push_back(got);
         end
      end
      outstanding = awaited_replies.size();
      fill_level = held;
   end

endmodule

`default_nettype wire

FILE: sim/testbench.sv
`default_nettype none

// Top of the sorted list engine bench. It makes the stimulus and gives the
// verdict; all prediction and comparison happens in the checker beside the
// block, which also exports the current fill level so that the stimulus
// can aim positions at entries that are actually held.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import sle_pkg::*;

   localparam int Depth = 16;
   localparam int RandomWords = 630;

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   logic [1:0]           req_op;
   logic [WordW-1:0]     req_item_key;
   logic [WordW-1:0]     req_item_value;
   logic [PosW-1:0]      req_position;
   logic                 rsp_valid;
   logic [WordW-1:0]     rsp_found_key;
   logic [WordW-1:0]     rsp_found_value;
   logic [CountOutW-1:0] rsp_entry_count;
   logic [1:0]           rsp_status;

   int mismatches;
   int outstanding;
   int fill_level;
   int full_replies;
   int badpos_replies;

   // Number of words sent, split by operation.
   int words_by_op [4];

   sorted_list_engine #(
      .LIST_DEPTH(Depth)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_op(req_op),
      .req_item_key(req_item_key),
      .req_item_value(req_item_value),
      .req_position(req_position),
      .rsp_valid(rsp_valid),
      .rsp_found_key(rsp_found_key),
      .rsp_found_value(rsp_found_value),
      .rsp_entry_count(rsp_entry_count),
      .rsp_status(rsp_status)
   );

   sorted_list_checker #(
      .DEPTH(Depth)
   ) checker_inst (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_op(req_op),
      .req_item_key(req_item_key),
      .req_item_value(req_item_value),
      .req_position(req_position),
      .rsp_valid(rsp_valid),
      .rsp_found_key(rsp_found_key),
      .rsp_found_value(rsp_found_value),
      .rsp_entry_count(rsp_entry_count),
      .rsp_status(rsp_status),
      .mismatches(mismatches),
      .outstanding(outstanding),
      .fill_level(fill_level),
      .full_replies(full_replies),
      .badpos_replies(badpos_replies)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // A correct run with the longest idle bursts ends well inside this limit,
   // so it only trips when the handshake hangs.
   initial begin
      #500_000;
      $display("Timeout: the block stopped taking or answering words.");
      $display("DONE: errors detected");
      $finish;
   end

   // Idle cycles with start low. The request fields carry random junk meanwhile
   // so that the block is seen to ignore them.
   task automatic idle_for(int cycles);
      repeat (cycles) begin
         @(negedge clock);
         start = 1'b0;
         req_op = 2'($urandom_range(3));
         req_item_key = $urandom();
         req_item_value = $urandom();
         req_position = PosW'($urandom_range(15));
      end
   endtask

   // Presents one request word at the falling edge and holds it until a rising
   // edge sees busy low. Start is left high, so back-to-back words keep it high
   // without a glitch; the next idle cycle is what lowers it.
   task automatic send_word(op_type op, logic [WordW-1:0] key, logic [WordW-1:0] value,
                            logic [PosW-1:0] pos);
      @(negedge clock);
      start = 1'b1;
      req_op = op;
      req_item_key = key;
      req_item_value = value;
      req_position = pos;
      words_by_op[op]++;
      do @(posedge clock); while (busy !== 1'b0);
   endtask

   // Keys come from three pools: a tiny range that forces many equal keys,
   // the full 32-bit range, and the boundary values around the sign bit and
   // the ends of the range.
   function automatic logic [WordW-1:0] pick_key();
      int pool;
      pool = $urandom_range(99);
      if (pool < 40) return WordW'($urandom_range(7));
      if (pool < 85) return $urandom();
      case ($urandom_range(3))
         0: return '0;
         1: return '1;
         2: return 32'h7FFF_FFFF;
         default: return 32'h8000_0000;
      endcase
   endfunction

   initial begin
      int idle_pct;
      bit filling;
      int roll;
      int guard;
      op_type op;
      logic [PosW-1:0] pos;

      foreach (words_by_op[i]) words_by_op[i] = 0;
      reset = 1'b1;
      start = 1'b0;
      req_op = OP_INSERT;
      req_item_key = '0;
      req_item_value = '0;
      req_position = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part. On the empty list a count, a read and a delete must all
      // report the empty state, the last two with the position-not-held status.
      send_word(OP_COUNT, $urandom(), $urandom(), 4'd0);
      send_word(OP_READ, $urandom(), $urandom(), 4'd0);
      send_word(OP_DELETE, $urandom(), $urandom(), 4'd15);
      // Extreme keys and values, inserted out of order.
      send_word(OP_INSERT, '1, '1, PosW'($urandom()));
      send_word(OP_INSERT, '0, '0, PosW'($urandom()));
      // Two equal keys: the newer one must land in front of the older one,
      // which the read at position one then shows.
      send_word(OP_INSERT, 32'd5, 32'hAAAA_AAAA, PosW'($urandom()));
      send_word(OP_INSERT, 32'd5, 32'h5555_5555, PosW'($urandom()));
      send_word(OP_READ, $urandom(), $urandom(), 4'd1);
      // Fill the list to the top with many duplicate keys, then try one more
      // insert, which must be refused as full and leave the list alone.
      repeat (Depth - 4) send_word(OP_INSERT, WordW'($urandom_range(6)), $urandom(),
                                   PosW'($urandom()));
      send_word(OP_INSERT, 32'd1, 32'hDEAD_0001, PosW'($urandom()));
      // The last position, then removal at both ends of a full list.
      send_word(OP_READ, $urandom(), $urandom(), 4'd15);
      send_word(OP_DELETE, $urandom(), $urandom(), 4'd15);
      send_word(OP_DELETE, $urandom(), $urandom(), 4'd0);
      send_word(OP_COUNT, $urandom(), $urandom(), PosW'($urandom()));

      // Random part. The mix swings between a filling trend and a draining
      // trend so that the list sweeps between empty and full many times, and
      // most positions fall on entries that are held.
      filling = 1'b1;
      idle_pct = 0;
      for (int k = 0; k < RandomWords; k++) begin
         if (k % 40 == 0) begin
            // Idle density changes per segment, so there are stretches with
            // no gaps at all; the final stretch runs flat out.
            if (k >= RandomWords - 100) idle_pct = 0;
            else idle_pct = 25 * $urandom_range(2);
         end
         if (k == RandomWords / 2) begin
            // Hold off until the block has answered everything sent so far.
            idle_for(1);
            while (outstanding != 0) @(negedge clock);
         end
         if (idle_pct > 0 && $urandom_range(99) < idle_pct) idle_for($urandom_range(1, 4));

         if (fill_level >= Depth && $urandom_range(99) < 30) filling = 1'b0;
         else if (fill_level == 0) filling = 1'b1;
         else if ($urandom_range(99) < 2) filling = ~filling;

         roll = $urandom_range(99);
         if (filling) begin
            if (roll < 55) op = OP_INSERT;
            else if (roll < 70) op = OP_DELETE;
            else if (roll < 93) op = OP_READ;
            else op = OP_COUNT;
         end else begin
            if (roll < 15) op = OP_INSERT;
            else if (roll < 65) op = OP_DELETE;
            else if (roll < 93) op = OP_READ;
            else op = OP_COUNT;
         end

         if (fill_level > 0 && $urandom_range(99) < 85) pos = PosW'($urandom_range(fill_level - 1));
         else pos = PosW'($urandom_range(15));

         send_word(op, pick_key(), $urandom(), pos);
      end
      idle_for(1);

      // Drain: the last result comes in the cycle after its word, so a short
      // bounded wait is plenty, followed by a few quiet cycles.
      guard = 0;
      while (outstanding != 0 && guard < 100) begin
         @(negedge clock);
         guard++;
      end
      repeat (4) @(negedge clock);

      $display("Sent %0d words: %0d insert, %0d delete, %0d read, %0d count.",
               words_by_op[0] + words_by_op[1] + words_by_op[2] + words_by_op[3],
               words_by_op[OP_INSERT], words_by_op[OP_DELETE], words_by_op[OP_READ],
               words_by_op[OP_COUNT]);
      $display("Refused as full: %0d; position not held: %0d; results never seen: %0d.",
               full_replies, badpos_replies, outstanding);
      if (mismatches == 0 && outstanding == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

`default_nettype wire
